// File: rtl/core/windowed_temperature_statistics_unit_assert.svh
// assertion macros used by the statistics unit
`ifndef WINDOWED_TEMPERATURE_STATISTICS_UNIT_ASSERT_SVH
`define WINDOWED_TEMPERATURE_STATISTICS_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define WTS_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("statistics unit: same-cycle check failed");

// next-cycle implication, checked outside reset
`define WTS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("statistics unit: next-cycle check failed");

`endif

// File: rtl/core/wts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wts_pkg;

   localparam int ADC_BITS           = 12;
   localparam int MAX_WINDOW_DEFAULT = 4096;
   localparam int LEN_W              = 13;
   localparam int OFF_W              = 12;
   localparam int CPD_W              = 12;
   localparam int FRAC_BITS          = 8;
   localparam int DEG_W              = 20;
   localparam int DEG_MAX            = 524287;
   localparam int DEG_MIN_MAG        = 524288;
   localparam int QUEUE_DEPTH        = 2;

   // register indexes, byte address bits [3:2]
   typedef enum logic [1:0] {
      REG_WINDOW_LENGTH     = 2'd0,
      REG_ADC_OFFSET        = 2'd1,
      REG_COUNTS_PER_DEGREE = 2'd2
   } reg_index_type;

endpackage

`default_nettype wire

// File: rtl/core/wts_front.sv
`timescale 1ns / 1ps
`default_nettype none

module wts_front #(
   parameter int MAX_WINDOW = wts_pkg::MAX_WINDOW_DEFAULT,
   localparam int CNT_W = $clog2(MAX_WINDOW + 1),
   localparam int SUM_W = wts_pkg::ADC_BITS + CNT_W,
   localparam int JOB_W = 3 * wts_pkg::ADC_BITS + 1 + SUM_W + CNT_W
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [wts_pkg::LEN_W-1:0]     window_length,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [wts_pkg::ADC_BITS-1:0]  in_raw,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [JOB_W-1:0]                   out_job
);

   localparam int ADC   = wts_pkg::ADC_BITS;
   localparam int CMP_W = (wts_pkg::LEN_W > CNT_W) ? wts_pkg::LEN_W : CNT_W;

   typedef struct packed {
      logic [ADC-1:0]   raw;
      logic             close;
      logic [ADC-1:0]   min_raw;
      logic [ADC-1:0]   max_raw;
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
   } job_type;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [ADC-1:0]   min_ff, min_in;
   logic [ADC-1:0]   max_ff, max_in;
   logic [SUM_W-1:0] sum_ff, sum_in;

   logic [CMP_W-1:0] len_ext;
   logic [CMP_W-1:0] eff_len;
   logic [CNT_W-1:0] n_next;
   logic [ADC-1:0]   min_next;
   logic [ADC-1:0]   max_next;
   logic [SUM_W-1:0] sum_next;
   logic             close;
   logic             accept;
   job_type          job;

   assign in_ready  = out_ready;
   assign out_valid = in_valid;
   assign accept    = in_valid & out_ready;

   always_comb begin
      len_ext = CMP_W'(window_length);
      priority if (len_ext == '0) begin
         eff_len = CMP_W'(1);
      end else if (len_ext > CMP_W'(MAX_WINDOW)) begin
         eff_len = CMP_W'(MAX_WINDOW);
      end else begin
         eff_len = len_ext;
      end
      n_next   = count_ff + 1'b1;
      min_next = (in_raw < min_ff) ? in_raw : min_ff;
      max_next = (in_raw > max_ff) ? in_raw : max_ff;
      sum_next = sum_ff + SUM_W'(in_raw);
      close    = (CMP_W'(n_next) >= eff_len);

      job.raw     = in_raw;
      job.close   = close;
      job.min_raw = min_next;
      job.max_raw = max_next;
      job.sum     = sum_next;
      job.count   = n_next;
   end

   assign out_job = job;

   // accepted item: accumulate, or when the window closes start over empty
   always_comb begin
      count_in = count_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      sum_in   = sum_ff;
      if (accept) begin
         if (close) begin
            count_in = '0;
            min_in   = '1;
            max_in   = '0;
            sum_in   = '0;
         end else begin
            count_in = n_next;
            min_in   = min_next;
            max_in   = max_next;
            sum_in   = sum_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         min_ff   <= '1;
         max_ff   <= '0;
         sum_ff   <= '0;
      end else begin
         count_ff <= count_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         sum_ff   <= sum_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/wts_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module wts_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = wts_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [WIDTH-1:0]      out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             push;
   logic             pop;

   assign in_ready  = (fill_ff != CNT_W'(DEPTH));
   assign out_valid = (fill_ff != '0);
   assign out_data  = mem[rd_ptr_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/wts_back.sv
`timescale 1ns / 1ps
`default_nettype none

module wts_back #(
   parameter int MAX_WINDOW = wts_pkg::MAX_WINDOW_DEFAULT,
   localparam int CNT_W = $clog2(MAX_WINDOW + 1),
   localparam int SUM_W = wts_pkg::ADC_BITS + CNT_W,
   localparam int JOB_W = 3 * wts_pkg::ADC_BITS + 1 + SUM_W + CNT_W
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         job_valid,
   output logic                              job_ready,
   input  wire logic [JOB_W-1:0]             job,
   input  wire logic [wts_pkg::OFF_W-1:0]    adc_offset,
   input  wire logic [wts_pkg::CPD_W-1:0]    cpd_eff,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [4*wts_pkg::DEG_W-1:0]       rsp_data,
   output logic                              rsp_done
);

   localparam int ADC   = wts_pkg::ADC_BITS;
   localparam int DEG_W = wts_pkg::DEG_W;
   localparam int FRAC  = wts_pkg::FRAC_BITS;
   localparam int PO_W  = CNT_W + wts_pkg::OFF_W;
   localparam int DEN_W = CNT_W + wts_pkg::CPD_W;
   localparam int DIV_W = SUM_W + FRAC;
   localparam int ITER_W = $clog2(DIV_W);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_STORE = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   localparam logic [1:0] OP_CUR  = 2'd0;
   localparam logic [1:0] OP_MIN  = 2'd1;
   localparam logic [1:0] OP_MAX  = 2'd2;
   localparam logic [1:0] OP_MEAN = 2'd3;

   typedef struct packed {
      logic [ADC-1:0]   raw;
      logic             close;
      logic [ADC-1:0]   min_raw;
      logic [ADC-1:0]   max_raw;
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
   } job_type;

   logic [2:0]        state_ff, state_in;
   logic [1:0]        op_ff, op_in;
   job_type           job_ff, job_in;
   logic [PO_W-1:0]   prod_off_ff, prod_off_in;
   logic [DEN_W-1:0]  prod_den_ff, prod_den_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [DEG_W-1:0]  cur_ff, cur_in;
   logic [DEG_W-1:0]  min_ff, min_in;
   logic [DEG_W-1:0]  max_ff, max_in;
   logic [DEG_W-1:0]  avg_ff, avg_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [4*DEG_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_done_ff, rsp_done_in;

   logic [ADC-1:0]    sval;
   logic [ADC:0]      sdiff;
   logic [ADC-1:0]    smag;
   logic [SUM_W:0]    mdiff;
   logic [SUM_W-1:0]  mmag;
   logic              load_neg;
   logic [DIV_W-1:0]  load_div;
   logic [DEN_W-1:0]  load_den;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    trial_sub;
   logic              trial_ge;
   logic [DIV_W-1:0]  quo_neg;
   logic [DEG_W-1:0]  sat_val;
   logic              emit_fire;

   assign job_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_done  = rsp_done_ff;
   assign emit_fire = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   // operand set-up for the division of the current op
   always_comb begin
      unique case (op_ff)
         OP_CUR:  sval = job_ff.raw;
         OP_MIN:  sval = job_ff.min_raw;
         OP_MAX:  sval = job_ff.max_raw;
         OP_MEAN: sval = job_ff.raw;
      endcase
      sdiff = {1'b0, sval} - (ADC + 1)'(adc_offset);
      smag  = sdiff[ADC] ? ADC'(-sdiff) : sdiff[ADC-1:0];
      mdiff = (SUM_W + 1)'(job_ff.sum) - (SUM_W + 1)'(prod_off_ff);
      mmag  = mdiff[SUM_W] ? SUM_W'(-mdiff) : mdiff[SUM_W-1:0];
      if (op_ff == OP_MEAN) begin
         load_neg = mdiff[SUM_W];
         load_div = {mmag, {FRAC{1'b0}}};
         load_den = prod_den_ff;
      end else begin
         load_neg = sdiff[ADC];
         load_div = DIV_W'({smag, {FRAC{1'b0}}});
         load_den = DEN_W'(cpd_eff);
      end
   end

   // restoring step, one quotient bit
   always_comb begin
      trial     = {rem_ff, quo_ff[DIV_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      trial_ge  = (trial >= {1'b0, den_ff});
   end

   // saturate the magnitude and apply the sign
   always_comb begin
      quo_neg = ~quo_ff + 1'b1;
      if (neg_ff) begin
         sat_val = (quo_ff > DIV_W'(wts_pkg::DEG_MIN_MAG)) ?
                   DEG_W'(wts_pkg::DEG_MIN_MAG) : quo_neg[DEG_W-1:0];
      end else begin
         sat_val = (quo_ff > DIV_W'(wts_pkg::DEG_MAX)) ?
                   DEG_W'(wts_pkg::DEG_MAX) : quo_ff[DEG_W-1:0];
      end
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      job_in      = job_ff;
      prod_off_in = prod_off_ff;
      prod_den_in = prod_den_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      den_in      = den_ff;
      neg_in      = neg_ff;
      iter_in     = iter_ff;
      cur_in      = cur_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      avg_in      = avg_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_in   = job;
               op_in    = OP_CUR;
               min_in   = '0;
               max_in   = '0;
               avg_in   = '0;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            prod_off_in = PO_W'(job_ff.count) * PO_W'(adc_offset);
            prod_den_in = DEN_W'(job_ff.count) * DEN_W'(cpd_eff);
            state_in    = ST_LOAD;
         end
         ST_LOAD: begin
            quo_in   = load_div;
            rem_in   = '0;
            den_in   = load_den;
            neg_in   = load_neg;
            iter_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_in  = {quo_ff[DIV_W-2:0], trial_ge};
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(DIV_W - 1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            unique case (op_ff)
               OP_CUR:  cur_in = sat_val;
               OP_MIN:  min_in = sat_val;
               OP_MAX:  max_in = sat_val;
               OP_MEAN: avg_in = sat_val;
            endcase
            if ((op_ff == OP_MEAN) || !job_ff.close) begin
               state_in = ST_EMIT;
            end else begin
               op_in    = op_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_EMIT: begin
            if (emit_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_done_in  = rsp_done_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {avg_ff, max_ff, min_ff, cur_ff};
         rsp_done_in  = job_ff.close;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_CUR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      prod_off_ff <= prod_off_in;
      prod_den_ff <= prod_den_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      den_ff      <= den_in;
      neg_ff      <= neg_in;
      iter_ff     <= iter_in;
      cur_ff      <= cur_in;
      min_ff      <= min_in;
      max_ff      <= max_in;
      avg_ff      <= avg_in;
      rsp_data_ff <= rsp_data_in;
      rsp_done_ff <= rsp_done_in;
   end

endmodule

`default_nettype wire

// File: rtl/core/windowed_temperature_statistics_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Windowed temperature statistics. Every raw ADC item on req_ gives one result item on rsp_:
// the sample in degrees ((raw - adc_offset) * 256 / counts_per_degree, truncated toward
// zero, saturated to 20 bits signed, 8 fraction bits) and, on the item that closes a window
// of window_length samples, window_done set with the converted minimum, maximum and mean
// (zero otherwise). A front stage keeps the running raw minimum, maximum, sum and count and
// classifies each item; a two-entry queue hands it to a back stage that owns one restoring
// divider producing one quotient bit per cycle, DIV_W = ADC_BITS + clog2(MAX_WINDOW + 1) + 8
// quotient bits wide; an ordinary item runs one division, a window-closing item four. The
// front takes new items while the queue has room, and the back stage may convert its next
// item while a result still waits in the output register, holding it in the emit state
// until that register frees. Length 0 is taken as 1, lengths above MAX_WINDOW as
// MAX_WINDOW, counts_per_degree 0 as 1. Registers are to be written only while the block
// is idle; the block itself does not enforce it. No clearing pass after reset.

`include "windowed_temperature_statistics_unit_assert.svh"

module windowed_temperature_statistics_unit #(
   parameter int MAX_WINDOW = wts_pkg::MAX_WINDOW_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: sample_raw [11:0], zero fill [15:12]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,
   // rsp_tdata: current_temp [19:0], min_temp [39:20], max_temp [59:40], avg_temp [79:60]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,
   // rsp_tuser: window_done [0]
   output logic             rsp_tuser,
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = wts_pkg::ADC_BITS + CNT_W;
   localparam int JOB_W = 3 * wts_pkg::ADC_BITS + 1 + SUM_W + CNT_W;

   localparam logic [wts_pkg::LEN_W-1:0] RST_WINDOW_LENGTH = 13'd1200;
   localparam logic [wts_pkg::OFF_W-1:0] RST_ADC_OFFSET    = 12'd2048;
   localparam logic [wts_pkg::CPD_W-1:0] RST_COUNTS        = 12'd41;

   logic [wts_pkg::LEN_W-1:0] window_length_ff, window_length_in;
   logic [wts_pkg::OFF_W-1:0] adc_offset_ff, adc_offset_in;
   logic [wts_pkg::CPD_W-1:0] counts_ff, counts_in;
   logic [wts_pkg::CPD_W-1:0] cpd_eff;
   logic                      csr_write;

   logic                      front_valid;
   logic                      front_ready;
   logic [JOB_W-1:0]          front_job;
   logic                      queue_valid;
   logic                      queue_ready;
   logic [JOB_W-1:0]          queue_job;

   logic signed [wts_pkg::DEG_W-1:0] rsp_min;
   logic signed [wts_pkg::DEG_W-1:0] rsp_max;
   logic signed [wts_pkg::DEG_W-1:0] rsp_avg;

   // register port: no wait states
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      window_length_in = window_length_ff;
      adc_offset_in    = adc_offset_ff;
      counts_in        = counts_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            wts_pkg::REG_WINDOW_LENGTH:
               window_length_in = csr_pwdata[wts_pkg::LEN_W-1:0];
            wts_pkg::REG_ADC_OFFSET:
               adc_offset_in    = csr_pwdata[wts_pkg::OFF_W-1:0];
            wts_pkg::REG_COUNTS_PER_DEGREE:
               counts_in        = csr_pwdata[wts_pkg::CPD_W-1:0];
            default: begin
               // address past the register list: write is dropped
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         wts_pkg::REG_WINDOW_LENGTH:     csr_prdata = 32'(window_length_ff);
         wts_pkg::REG_ADC_OFFSET:        csr_prdata = 32'(adc_offset_ff);
         wts_pkg::REG_COUNTS_PER_DEGREE: csr_prdata = 32'(counts_ff);
         default:                        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= RST_WINDOW_LENGTH;
         adc_offset_ff    <= RST_ADC_OFFSET;
         counts_ff        <= RST_COUNTS;
      end else begin
         window_length_ff <= window_length_in;
         adc_offset_ff    <= adc_offset_in;
         counts_ff        <= counts_in;
      end
   end

   // a zero divisor behaves as one
   assign cpd_eff = (counts_ff == '0) ? wts_pkg::CPD_W'(1) : counts_ff;

   // front: running window statistics and window-close decision
   wts_front #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .window_length (window_length_ff),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_raw        (req_tdata[wts_pkg::ADC_BITS-1:0]),
      .out_valid     (front_valid),
      .out_ready     (front_ready),
      .out_job       (front_job)
   );

   // short queue decoupling the two halves
   wts_queue #(
      .WIDTH (JOB_W),
      .DEPTH (wts_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_job),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_data  (queue_job)
   );

   // back: conversions through the shared divider, output register
   wts_back #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (queue_valid),
      .job_ready  (queue_ready),
      .job        (queue_job),
      .adc_offset (adc_offset_ff),
      .cpd_eff    (cpd_eff),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (rsp_tdata),
      .rsp_done   (rsp_tuser)
   );

   assign rsp_min = rsp_tdata[39:20];
   assign rsp_max = rsp_tdata[59:40];
   assign rsp_avg = rsp_tdata[79:60];

   // statistics fields stay zero on items that do not close a window
   `WTS_ASSERT_IMPLIES(a_stats_zero_when_open, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[79:20] == '0)
   // conversion is monotonic, so the mean lies between minimum and maximum
   `WTS_ASSERT_IMPLIES(a_min_not_above_mean, clock, reset, rsp_tvalid && rsp_tuser, rsp_min <= rsp_avg)
   `WTS_ASSERT_IMPLIES(a_mean_not_above_max, clock, reset, rsp_tvalid && rsp_tuser, rsp_avg <= rsp_max)
   // a write to the window length register lands in the next cycle
   `WTS_ASSERT_NEXT(a_length_write, clock, reset, csr_write && (csr_paddr[3:2] == wts_pkg::REG_WINDOW_LENGTH), window_length_ff == $past(csr_pwdata[12:0]))

endmodule

`default_nettype wire
